// File: sv/tvt_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the vertex transform core and its normaliser.
package tvt_pkg;

   localparam int POS_W     = 32;
   localparam int NRM_W     = 16;
   localparam int COEF_W    = 16;
   localparam int ROW_W     = 48;
   localparam int VEC_W     = 62;
   localparam int CSR_IDX_W = 3;
   localparam int EPS_W     = 16;

   // One in Q2.14
   localparam logic signed [NRM_W-1:0] UNIT_LEN = 16'sd16384;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Z = 3'd5;

   typedef struct packed {
      logic signed [POS_W-1:0] in_px;
      logic signed [POS_W-1:0] in_py;
      logic signed [POS_W-1:0] in_pz;
      logic signed [NRM_W-1:0] in_nx;
      logic signed [NRM_W-1:0] in_ny;
      logic signed [NRM_W-1:0] in_nz;
      logic                    normal_present;
      logic                    face_normal;
      logic [1:0]              corner;
   } tvt_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] out_px;
      logic signed [POS_W-1:0] out_py;
      logic signed [POS_W-1:0] out_pz;
      logic signed [NRM_W-1:0] out_nx;
      logic signed [NRM_W-1:0] out_ny;
      logic signed [NRM_W-1:0] out_nz;
      logic                    last;
   } tvt_rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [VEC_W-1:0] vx;
      logic signed [VEC_W-1:0] vy;
      logic signed [VEC_W-1:0] vz;
   } norm_req_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
   } norm_rsp_type;

   // Squared epsilon of the face normal test, in units of 2^(4s), s being the edge shift
   function automatic logic [EPS_W-1:0] face_eps(input logic [1:0] s);
      logic [EPS_W-1:0] r;
      case (s)
         2'd0: r = 16'd1844;
         2'd1: r = 16'd115;
         2'd2: r = 16'd7;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/triangle_vertex_transform_core.sv
`timescale 1ns / 1ps
// Triangle vertex transform core: affine position transform, normal rotation and face normals.
//
// Vertices arrive one beat at a time on the req_ channel (valid/ready). Each position is
// transformed by the affine matrix held in the csr_ registers; a supplied normal is rotated
// and renormalised, a missing one becomes (0,1,0). Corners 0 and 1 are held inside the block
// and give no result; corner 2 releases the whole triangle as three rsp_ beats, the third
// flagged last. With face_normal set on corner 2 all three carry the normalised edge cross
// product. A corner value of 3 is dropped.
// One vertex at a time: req_ready is high only while the sequencer is idle. A supplied normal
// is rotated and renormalised in the shared normaliser (32 square-root steps and 15 divide
// steps per component). A face-normal corner 2 skips the vertex normal and instead forms the
// edges and cross products and runs one normalisation on them before its first result.
// Results leave through a single output register; a stalled receiver holds the sequencer in
// its emit state, and the next vertex is taken once the last beat is registered.
// Reset is synchronous and active high: it restores the identity matrix and zero
// translation and empties the output register. Configuration writes are taken every cycle.
module triangle_vertex_transform_core
   import tvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tvt_req_type          req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tvt_rsp_type          rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROW_W-1:0]     csr_data
);

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 50;
   localparam int DOT_W  = 34;
   localparam int EDGE_W = 33;
   localparam int SCL_W  = 31;
   localparam int RND_W  = 38;
   localparam int SUM_W  = 39;

   typedef enum logic [3:0] {
      T_IDLE, T_MUL, T_POS, T_VNRM, T_VWAIT, T_STORE, T_EDGE, T_CROSS, T_FDEC, T_FWAIT,
      T_EMIT
   } tstate_type;

   typedef enum logic [1:0] {DST_POS, DST_NRM, DST_CRS, DST_CSQ} dst_type;

   typedef struct packed {
      logic       valid;
      dst_type    dst;
      logic [1:0] idx;
      logic       neg;
   } mul_tag_type;

   tstate_type                state_ff;
   logic [ROW_W-1:0]          row_ff [3];
   logic signed [POS_W-1:0]   shift_ff [3];
   tvt_req_type               req_ff;
   logic [4:0]                step_ff;
   logic [1:0]                mrow_ff;
   logic [1:0]                mcol_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   mul_tag_type               tag_ff;
   logic signed [ACC_W-1:0]   pos_acc_ff [3];
   logic signed [DOT_W-1:0]   d_acc_ff [3];
   logic signed [VEC_W-1:0]   c_ff [3];
   logic [EPS_W-1:0]          csq_ff;
   logic signed [POS_W-1:0]   pos_ff [3];
   logic signed [NRM_W-1:0]   vn_ff [3];
   logic signed [NRM_W-1:0]   fn_ff [3];
   logic signed [POS_W-1:0]   held_p_ff [2][3];
   logic signed [NRM_W-1:0]   held_n_ff [2][3];
   logic signed [SCL_W-1:0]   e1_ff [3];
   logic signed [SCL_W-1:0]   e2_ff [3];
   logic [1:0]                s_ff;
   logic [1:0]                idx_ff;
   logic                      rsp_valid_ff;
   tvt_rsp_type               rsp_ff;

   logic signed [COEF_W-1:0]  coef_in;
   logic signed [POS_W-1:0]   pin_in;
   logic signed [NRM_W-1:0]   nin_in;
   logic                      phase_in;
   logic signed [MUL_W-1:0]   mul_a_in;
   logic signed [MUL_W-1:0]   mul_b_in;
   mul_tag_type               tag_in;
   logic signed [ACC_W-1:0]   rnd_full_in;
   logic signed [SUM_W-1:0]   pos_sum_in;
   logic signed [POS_W-1:0]   pos_sat_in;
   logic                      vn_go_in;
   logic                      small_in;
   logic signed [SCL_W-1:0]   e1_in [3];
   logic signed [SCL_W-1:0]   e2_in [3];
   logic [1:0]                s_in;
   norm_req_type              norm_req;
   norm_rsp_type              norm_rsp;
   tvt_rsp_type               rsp_in;

   tvt_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .norm_req (norm_req),
      .norm_rsp (norm_rsp)
   );

   // Operand selection for the shared multiplier
   always_comb begin
      coef_in  = row_ff[mrow_ff][COEF_W*mcol_ff +: COEF_W];
      phase_in = (step_ff >= 5'd9);
      case (mcol_ff)
         2'd0: begin
            pin_in = req_ff.in_px;
            nin_in = req_ff.in_nx;
         end
         2'd1: begin
            pin_in = req_ff.in_py;
            nin_in = req_ff.in_ny;
         end
         default: begin
            pin_in = req_ff.in_pz;
            nin_in = req_ff.in_nz;
         end
      endcase
      mul_a_in = '0;
      mul_b_in = '0;
      tag_in   = '0;
      case (state_ff)
         T_MUL: begin
            if (step_ff < 5'd18) begin
               mul_a_in     = MUL_W'(coef_in);
               mul_b_in     = phase_in ? MUL_W'(nin_in) : MUL_W'(pin_in);
               tag_in.valid = 1'b1;
               tag_in.dst   = phase_in ? DST_NRM : DST_POS;
               tag_in.idx   = mrow_ff;
            end
         end
         T_CROSS: begin
            tag_in.valid = 1'b1;
            tag_in.dst   = DST_CRS;
            case (step_ff)
               5'd0: begin
                  mul_a_in = MUL_W'(e1_ff[1]);
                  mul_b_in = MUL_W'(e2_ff[2]);
                  tag_in.idx = 2'd0;
               end
               5'd1: begin
                  mul_a_in = MUL_W'(e1_ff[2]);
                  mul_b_in = MUL_W'(e2_ff[1]);
                  tag_in.idx = 2'd0;
                  tag_in.neg = 1'b1;
               end
               5'd2: begin
                  mul_a_in = MUL_W'(e1_ff[2]);
                  mul_b_in = MUL_W'(e2_ff[0]);
                  tag_in.idx = 2'd1;
               end
               5'd3: begin
                  mul_a_in = MUL_W'(e1_ff[0]);
                  mul_b_in = MUL_W'(e2_ff[2]);
                  tag_in.idx = 2'd1;
                  tag_in.neg = 1'b1;
               end
               5'd4: begin
                  mul_a_in = MUL_W'(e1_ff[0]);
                  mul_b_in = MUL_W'(e2_ff[1]);
                  tag_in.idx = 2'd2;
               end
               5'd5: begin
                  mul_a_in = MUL_W'(e1_ff[1]);
                  mul_b_in = MUL_W'(e2_ff[0]);
                  tag_in.idx = 2'd2;
                  tag_in.neg = 1'b1;
               end
               5'd6: begin
                  mul_a_in   = $signed(c_ff[0][MUL_W-1:0]);
                  mul_b_in   = $signed(c_ff[0][MUL_W-1:0]);
                  tag_in.dst = DST_CSQ;
               end
               5'd7: begin
                  mul_a_in   = $signed(c_ff[1][MUL_W-1:0]);
                  mul_b_in   = $signed(c_ff[1][MUL_W-1:0]);
                  tag_in.dst = DST_CSQ;
               end
               5'd8: begin
                  mul_a_in   = $signed(c_ff[2][MUL_W-1:0]);
                  mul_b_in   = $signed(c_ff[2][MUL_W-1:0]);
                  tag_in.dst = DST_CSQ;
               end
               default: tag_in.valid = 1'b0;
            endcase
         end
         default: tag_in.valid = 1'b0;
      endcase
   end

   // Round, translate and saturate one position row
   always_comb begin
      rnd_full_in = (pos_acc_ff[step_ff[1:0]] + ACC_W'(2048)) >>> 12;
      pos_sum_in  = SUM_W'($signed(rnd_full_in[RND_W-1:0])) + SUM_W'(shift_ff[step_ff[1:0]]);
      if (pos_sum_in[SUM_W-1:POS_W-1] == '0 || pos_sum_in[SUM_W-1:POS_W-1] == '1) begin
         pos_sat_in = pos_sum_in[POS_W-1:0];
      end else if (pos_sum_in[SUM_W-1]) begin
         pos_sat_in = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         pos_sat_in = {1'b0, {(POS_W-1){1'b1}}};
      end
   end

   // Edges truncated towards zero by a common shift
   always_comb begin
      logic signed [EDGE_W-1:0] r1 [3];
      logic signed [EDGE_W-1:0] r2 [3];
      logic [EDGE_W-1:0]        m1 [3];
      logic [EDGE_W-1:0]        m2 [3];
      logic [EDGE_W-1:0]        orv;
      logic signed [SCL_W-1:0]  t1;
      logic signed [SCL_W-1:0]  t2;
      orv = '0;
      for (int i = 0; i < 3; i++) begin
         r1[i] = EDGE_W'(held_p_ff[1][i]) - EDGE_W'(held_p_ff[0][i]);
         r2[i] = EDGE_W'(pos_ff[i]) - EDGE_W'(held_p_ff[0][i]);
         m1[i] = r1[i][EDGE_W-1] ? -r1[i] : r1[i];
         m2[i] = r2[i][EDGE_W-1] ? -r2[i] : r2[i];
         orv   = orv | m1[i] | m2[i];
      end
      if (orv[EDGE_W-1:30] == '0) begin
         s_in = 2'd0;
      end else if (orv[EDGE_W-1:31] == '0) begin
         s_in = 2'd1;
      end else if (!orv[EDGE_W-1]) begin
         s_in = 2'd2;
      end else begin
         s_in = 2'd3;
      end
      for (int i = 0; i < 3; i++) begin
         t1       = SCL_W'(m1[i] >> s_in);
         t2       = SCL_W'(m2[i] >> s_in);
         e1_in[i] = r1[i][EDGE_W-1] ? -t1 : t1;
         e2_in[i] = r2[i][EDGE_W-1] ? -t2 : t2;
      end
   end

   // Normaliser requests and the near-zero face test
   always_comb begin
      vn_go_in = req_ff.normal_present &&
                 ((d_acc_ff[0] != '0) || (d_acc_ff[1] != '0) || (d_acc_ff[2] != '0));
      small_in = (c_ff[0] > -VEC_W'(64)) && (c_ff[0] < VEC_W'(64)) &&
                 (c_ff[1] > -VEC_W'(64)) && (c_ff[1] < VEC_W'(64)) &&
                 (c_ff[2] > -VEC_W'(64)) && (c_ff[2] < VEC_W'(64)) &&
                 (csq_ff <= face_eps(s_ff));
      norm_req.start = ((state_ff == T_VNRM) && vn_go_in &&
                        !(req_ff.corner == 2'd2 && req_ff.face_normal)) ||
                       ((state_ff == T_FDEC) && !small_in);
      if (state_ff == T_FDEC) begin
         norm_req.vx = c_ff[0];
         norm_req.vy = c_ff[1];
         norm_req.vz = c_ff[2];
      end else begin
         norm_req.vx = VEC_W'(d_acc_ff[0]);
         norm_req.vy = VEC_W'(d_acc_ff[1]);
         norm_req.vz = VEC_W'(d_acc_ff[2]);
      end
   end

   // Result beat for the current emit slot
   always_comb begin
      case (idx_ff)
         2'd0: begin
            rsp_in.out_px = held_p_ff[0][0];
            rsp_in.out_py = held_p_ff[0][1];
            rsp_in.out_pz = held_p_ff[0][2];
            rsp_in.out_nx = req_ff.face_normal ? fn_ff[0] : held_n_ff[0][0];
            rsp_in.out_ny = req_ff.face_normal ? fn_ff[1] : held_n_ff[0][1];
            rsp_in.out_nz = req_ff.face_normal ? fn_ff[2] : held_n_ff[0][2];
            rsp_in.last   = 1'b0;
         end
         2'd1: begin
            rsp_in.out_px = held_p_ff[1][0];
            rsp_in.out_py = held_p_ff[1][1];
            rsp_in.out_pz = held_p_ff[1][2];
            rsp_in.out_nx = req_ff.face_normal ? fn_ff[0] : held_n_ff[1][0];
            rsp_in.out_ny = req_ff.face_normal ? fn_ff[1] : held_n_ff[1][1];
            rsp_in.out_nz = req_ff.face_normal ? fn_ff[2] : held_n_ff[1][2];
            rsp_in.last   = 1'b0;
         end
         default: begin
            rsp_in.out_px = pos_ff[0];
            rsp_in.out_py = pos_ff[1];
            rsp_in.out_pz = pos_ff[2];
            rsp_in.out_nx = req_ff.face_normal ? fn_ff[0] : vn_ff[0];
            rsp_in.out_ny = req_ff.face_normal ? fn_ff[1] : vn_ff[1];
            rsp_in.out_nz = req_ff.face_normal ? fn_ff[2] : vn_ff[2];
            rsp_in.last   = 1'b1;
         end
      endcase
   end

   // Sequencer, shared multiplier, accumulators and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         step_ff      <= '0;
         row_ff[0]    <= ROW_W'(48'd4096);
         row_ff[1]    <= ROW_W'(48'd4096) << 16;
         row_ff[2]    <= ROW_W'(48'd4096) << 32;
         shift_ff[0]  <= '0;
         shift_ff[1]  <= '0;
         shift_ff[2]  <= '0;
      end else begin
         // Configuration writes
         if (csr_valid) begin
            case (csr_index)
               CSR_ROW0:    row_ff[0]   <= csr_data;
               CSR_ROW1:    row_ff[1]   <= csr_data;
               CSR_ROW2:    row_ff[2]   <= csr_data;
               CSR_SHIFT_X: shift_ff[0] <= csr_data[POS_W-1:0];
               CSR_SHIFT_Y: shift_ff[1] <= csr_data[POS_W-1:0];
               CSR_SHIFT_Z: shift_ff[2] <= csr_data[POS_W-1:0];
               default: ;
            endcase
         end

         // Multiply, then accumulate the registered product in the next cycle
         prod_ff <= mul_a_in * mul_b_in;
         tag_ff  <= tag_in;
         if (tag_ff.valid) begin
            case (tag_ff.dst)
               DST_POS: pos_acc_ff[tag_ff.idx] <= pos_acc_ff[tag_ff.idx] +
                                                  prod_ff[ACC_W-1:0];
               DST_NRM: d_acc_ff[tag_ff.idx] <= d_acc_ff[tag_ff.idx] + prod_ff[DOT_W-1:0];
               DST_CRS: c_ff[tag_ff.idx] <= tag_ff.neg ?
                                            c_ff[tag_ff.idx] - prod_ff[VEC_W-1:0] :
                                            c_ff[tag_ff.idx] + prod_ff[VEC_W-1:0];
               default: csq_ff <= csq_ff + prod_ff[EPS_W-1:0];
            endcase
         end

         // Drop the output beat once taken; the emit state reloads it itself
         if (rsp_valid_ff && rsp_ready && state_ff != T_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            T_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_payload;
                  if (req_payload.corner != 2'd3) begin
                     step_ff  <= '0;
                     mrow_ff  <= '0;
                     mcol_ff  <= '0;
                     for (int i = 0; i < 3; i++) begin
                        pos_acc_ff[i] <= '0;
                        d_acc_ff[i]   <= '0;
                     end
                     state_ff <= T_MUL;
                  end
               end
            end
            T_MUL: begin
               step_ff <= step_ff + 5'd1;
               if (mcol_ff == 2'd2) begin
                  mcol_ff <= '0;
                  mrow_ff <= (mrow_ff == 2'd2) ? 2'd0 : mrow_ff + 2'd1;
               end else begin
                  mcol_ff <= mcol_ff + 2'd1;
               end
               if (step_ff == 5'd18) begin
                  step_ff  <= '0;
                  state_ff <= T_POS;
               end
            end
            T_POS: begin
               pos_ff[step_ff[1:0]] <= pos_sat_in;
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd2) begin
                  step_ff  <= '0;
                  state_ff <= T_VNRM;
               end
            end
            T_VNRM: begin
               if (req_ff.corner == 2'd2 && req_ff.face_normal) begin
                  state_ff <= T_STORE;
               end else if (vn_go_in) begin
                  state_ff <= T_VWAIT;
               end else begin
                  vn_ff[0] <= '0;
                  vn_ff[1] <= UNIT_LEN;
                  vn_ff[2] <= '0;
                  state_ff <= T_STORE;
               end
            end
            T_VWAIT: begin
               if (norm_rsp.done) begin
                  vn_ff[0] <= norm_rsp.nx;
                  vn_ff[1] <= norm_rsp.ny;
                  vn_ff[2] <= norm_rsp.nz;
                  state_ff <= T_STORE;
               end
            end
            T_STORE: begin
               if (!req_ff.corner[1]) begin
                  for (int i = 0; i < 3; i++) begin
                     held_p_ff[req_ff.corner[0]][i] <= pos_ff[i];
                     held_n_ff[req_ff.corner[0]][i] <= vn_ff[i];
                  end
                  state_ff <= T_IDLE;
               end else if (req_ff.face_normal) begin
                  state_ff <= T_EDGE;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= T_EMIT;
               end
            end
            T_EDGE: begin
               for (int i = 0; i < 3; i++) begin
                  e1_ff[i] <= e1_in[i];
                  e2_ff[i] <= e2_in[i];
                  c_ff[i]  <= '0;
               end
               s_ff     <= s_in;
               csq_ff   <= '0;
               step_ff  <= '0;
               state_ff <= T_CROSS;
            end
            T_CROSS: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd9) begin
                  step_ff  <= '0;
                  state_ff <= T_FDEC;
               end
            end
            T_FDEC: begin
               if (small_in) begin
                  fn_ff[0] <= '0;
                  fn_ff[1] <= UNIT_LEN;
                  fn_ff[2] <= '0;
                  idx_ff   <= '0;
                  state_ff <= T_EMIT;
               end else begin
                  state_ff <= T_FWAIT;
               end
            end
            T_FWAIT: begin
               if (norm_rsp.done) begin
                  fn_ff[0] <= norm_rsp.nx;
                  fn_ff[1] <= norm_rsp.ny;
                  fn_ff[2] <= norm_rsp.nz;
                  idx_ff   <= '0;
                  state_ff <= T_EMIT;
               end
            end
            T_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  idx_ff       <= idx_ff + 2'd1;
                  if (idx_ff == 2'd2) begin
                     idx_ff   <= '0;
                     state_ff <= T_IDLE;
                  end
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == T_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   // The normaliser is idle whenever a new vertex may enter
   a_norm_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !norm_rsp.busy)
      else $error("normaliser busy while accepting a vertex");

   // Normaliser results only arrive while the sequencer waits for them
   a_norm_done: assert property (@(posedge clock) disable iff (reset)
      norm_rsp.done |-> (state_ff == T_VWAIT || state_ff == T_FWAIT))
      else $error("normaliser result arrived outside a wait state");

   // A result beat only appears from the emit state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == T_EMIT))
      else $error("result beat raised outside emit");

   // Emitted normals stay within one in Q2.14
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.out_nx <= UNIT_LEN && rsp_ff.out_nx >= -UNIT_LEN &&
                        rsp_ff.out_ny <= UNIT_LEN && rsp_ff.out_ny >= -UNIT_LEN &&
                        rsp_ff.out_nz <= UNIT_LEN && rsp_ff.out_nz >= -UNIT_LEN))
      else $error("emitted normal exceeds unit length");

endmodule

// File: sv/tvt_norm.sv
`timescale 1ns / 1ps
// Iterative vector normaliser: block scaling, bit-serial square root, restoring divide.
module tvt_norm
   import tvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  norm_req_type norm_req,
   output norm_rsp_type norm_rsp
);

   localparam int SCL_W  = 30;
   localparam int QUO_W  = NRM_W - 1;
   localparam int LEN_W  = 31;
   localparam int NUM_W  = SCL_W + QUO_W + 1;
   localparam int ROOT_W = 64;

   typedef enum logic [2:0] {N_IDLE, N_SCALE, N_SQ, N_ROOT, N_DIV} nstate_type;

   nstate_type              state_ff;
   logic [VEC_W-1:0]        mag_ff [3];
   logic [2:0]              sign_ff;
   logic [1:0]              cnt_ff;
   logic [2*SCL_W-1:0]      sq_ff;
   logic                    sq_vld_ff;
   logic [VEC_W-1:0]        sum_ff;
   logic [ROOT_W-1:0]       v_ff;
   logic [ROOT_W-1:0]       res_ff;
   logic [ROOT_W-1:0]       bit_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [NUM_W-1:0]        rem_ff;
   logic [NUM_W-1:0]        dsh_ff;
   logic [QUO_W-1:0]        q_ff;
   logic [3:0]              step_ff;
   logic signed [NRM_W-1:0] n_ff [3];
   logic                    done_ff;

   logic [VEC_W-1:0]        mx_in;
   logic [SCL_W-1:0]        sq_op_in;
   logic [2*SCL_W-1:0]      sq_in;
   logic [VEC_W-1:0]        sum_in;
   logic [ROOT_W-1:0]       t_in;
   logic                    root_ge_in;
   logic [ROOT_W-1:0]       res_in;
   logic                    div_ge_in;
   logic [QUO_W-1:0]        q_in;
   logic signed [NRM_W-1:0] n_in;
   logic [VEC_W-1:0]        mag_nxt_in;

   function automatic logic [VEC_W-1:0] mag_of(input logic signed [VEC_W-1:0] v);
      logic [VEC_W-1:0] u;
      u = v;
      return v[VEC_W-1] ? (~u + 1'b1) : u;
   endfunction

   // Numerator of the rounded quotient: a * 2^15 + len
   function automatic logic [NUM_W-1:0] num_of(input logic [VEC_W-1:0] a,
                                                input logic [LEN_W-1:0] len);
      return {1'b0, a[SCL_W-1:0], {QUO_W{1'b0}}} + NUM_W'(len);
   endfunction

   // Largest magnitude, square operand and sums
   always_comb begin
      mx_in = mag_ff[0];
      if (mag_ff[1] > mx_in) begin
         mx_in = mag_ff[1];
      end
      if (mag_ff[2] > mx_in) begin
         mx_in = mag_ff[2];
      end
      case (cnt_ff)
         2'd0: sq_op_in = mag_ff[0][SCL_W-1:0];
         2'd1: sq_op_in = mag_ff[1][SCL_W-1:0];
         2'd2: sq_op_in = mag_ff[2][SCL_W-1:0];
         default: sq_op_in = '0;
      endcase
      case (cnt_ff)
         2'd0: mag_nxt_in = mag_ff[1];
         default: mag_nxt_in = mag_ff[2];
      endcase
      sq_in      = sq_op_in * sq_op_in;
      sum_in     = sum_ff + (sq_vld_ff ? VEC_W'(sq_ff) : '0);
      t_in       = res_ff + bit_ff;
      root_ge_in = v_ff >= t_in;
      res_in     = root_ge_in ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
      div_ge_in  = rem_ff >= dsh_ff;
      q_in       = {q_ff[QUO_W-2:0], div_ge_in};
      n_in       = sign_ff[cnt_ff] ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= N_IDLE;
         done_ff   <= 1'b0;
         sq_vld_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (norm_req.start) begin
                  mag_ff[0] <= mag_of(norm_req.vx);
                  mag_ff[1] <= mag_of(norm_req.vy);
                  mag_ff[2] <= mag_of(norm_req.vz);
                  sign_ff   <= {norm_req.vz[VEC_W-1], norm_req.vy[VEC_W-1],
                                norm_req.vx[VEC_W-1]};
                  state_ff  <= N_SCALE;
               end
            end
            // Bring the largest magnitude into [2^29, 2^30)
            N_SCALE: begin
               if (mx_in == '0) begin
                  n_ff[0]  <= '0;
                  n_ff[1]  <= UNIT_LEN;
                  n_ff[2]  <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else if (mx_in[VEC_W-1:34] != '0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 4;
               end else if (mx_in[VEC_W-1:30] != '0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else if (mx_in[VEC_W-1:25] == '0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 4;
               end else if (!mx_in[29]) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
               end else begin
                  cnt_ff    <= '0;
                  sum_ff    <= '0;
                  sq_vld_ff <= 1'b0;
                  state_ff  <= N_SQ;
               end
            end
            // Sum of squares, one product a cycle
            N_SQ: begin
               sq_ff     <= sq_in;
               sq_vld_ff <= (cnt_ff != 2'd3);
               sum_ff    <= sum_in;
               cnt_ff    <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  v_ff     <= ROOT_W'(sum_in);
                  res_ff   <= '0;
                  bit_ff   <= ROOT_W'(1) << 62;
                  state_ff <= N_ROOT;
               end
            end
            // Integer square root, two radicand bits a cycle
            N_ROOT: begin
               if (root_ge_in) begin
                  v_ff <= v_ff - t_in;
               end
               res_ff <= res_in;
               bit_ff <= bit_ff >> 2;
               if (bit_ff == ROOT_W'(1)) begin
                  len_ff   <= res_in[LEN_W-1:0];
                  cnt_ff   <= '0;
                  rem_ff   <= num_of(mag_ff[0], res_in[LEN_W-1:0]);
                  dsh_ff   <= {res_in[LEN_W-1:0], {QUO_W{1'b0}}};
                  step_ff  <= '0;
                  state_ff <= N_DIV;
               end
            end
            // Restoring divide by 2*len, one quotient bit a cycle
            N_DIV: begin
               if (div_ge_in) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               dsh_ff  <= dsh_ff >> 1;
               q_ff    <= q_in;
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(QUO_W - 1)) begin
                  n_ff[cnt_ff] <= n_in;
                  step_ff      <= '0;
                  if (cnt_ff == 2'd2) begin
                     done_ff  <= 1'b1;
                     state_ff <= N_IDLE;
                  end else begin
                     cnt_ff <= cnt_ff + 2'd1;
                     rem_ff <= num_of(mag_nxt_in, len_ff);
                     dsh_ff <= {len_ff, {QUO_W{1'b0}}};
                  end
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   assign norm_rsp.busy = (state_ff != N_IDLE);
   assign norm_rsp.done = done_ff;
   assign norm_rsp.nx   = n_ff[0];
   assign norm_rsp.ny   = n_ff[1];
   assign norm_rsp.nz   = n_ff[2];

endmodule

// File: dv/triangle_vertex_transform_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the triangle vertex transform core.
module triangle_vertex_transform_core_test;
   import tvt_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   tvt_req_type          req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   tvt_rsp_type          rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ROW_W-1:0]     csr_data;

   triangle_vertex_transform_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Shadow copy of the matrix and the held corners
   logic [ROW_W-1:0]        mat_row [3];
   logic signed [POS_W-1:0] mat_shift [3];
   longint                  held_pos [6];
   longint                  held_nrm [6];

   tvt_rsp_type vertices_due [$];
   int          errors = 0;
   int          idle_pct;
   int          stall_pct;
   int          quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Abort when no beat of any channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Compare every result beat against the oldest predicted vertex
   always @(posedge clock) begin
      tvt_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (vertices_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $time, rsp_payload);
         end else begin
            want = vertices_due.pop_front();
            if (rsp_payload.out_px !== want.out_px || rsp_payload.out_py !== want.out_py
                || rsp_payload.out_pz !== want.out_pz || rsp_payload.out_nx !== want.out_nx
                || rsp_payload.out_ny !== want.out_ny || rsp_payload.out_nz !== want.out_nz
                || rsp_payload.last !== want.last) begin
               errors++;
               $display("%0t: mismatch expected p=(%0d,%0d,%0d) n=(%0d,%0d,%0d) last=%0b",
                        $time, want.out_px, want.out_py, want.out_pz,
                        want.out_nx, want.out_ny, want.out_nz, want.last);
               $display("%0t:          actual p=(%0d,%0d,%0d) n=(%0d,%0d,%0d) last=%0b",
                        $time, rsp_payload.out_px, rsp_payload.out_py, rsp_payload.out_pz,
                        rsp_payload.out_nx, rsp_payload.out_ny, rsp_payload.out_nz,
                        rsp_payload.last);
            end
         end
      end
   end

   function automatic longint lane(input int r, input int k);
      logic signed [COEF_W-1:0] c;
      c = mat_row[r][COEF_W*k +: COEF_W];
      return longint'(c);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bits;
      res  = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v   = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   // Scale to unit length in Q2.14, rounding half away from zero
   function automatic void unit_vector(input longint c0, input longint c1, input longint c2,
                                       output longint n0, output longint n1,
                                       output longint n2);
      longint          c [3];
      longint          n [3];
      longint unsigned a [3];
      longint unsigned mx, sum, len, q;
      c  = '{c0, c1, c2};
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = c[i] < 0 ? -c[i] : c[i];
         if (a[i] > mx) mx = a[i];
      end
      if (mx == 0) begin
         n0 = 0; n1 = 16384; n2 = 0;
         return;
      end
      while (mx >= (64'd1 << 30)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) a[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += a[i] * a[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q    = (2 * a[i] * 16384 + len) / (2 * len);
         n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      n0 = n[0]; n1 = n[1]; n2 = n[2];
   endfunction

   function automatic longint trunc_shift(input longint v, input int s);
      return v < 0 ? -((-v) >>> s) : (v >>> s);
   endfunction

   // Flat normal from the edges p1-p0 and p2-p0, with the near-zero fallback
   function automatic void flat_normal(input longint p2x, input longint p2y,
                                       input longint p2z, output longint n0,
                                       output longint n1, output longint n2);
      longint          e1 [3];
      longint          e2 [3];
      longint          c [3];
      longint          p2 [3];
      longint unsigned mx, cm, sum, a, b;
      int              s;
      p2 = '{p2x, p2y, p2z};
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         e1[i] = held_pos[3+i] - held_pos[i];
         e2[i] = p2[i] - held_pos[i];
         a = e1[i] < 0 ? -e1[i] : e1[i];
         b = e2[i] < 0 ? -e2[i] : e2[i];
         if (a > mx) mx = a;
         if (b > mx) mx = b;
      end
      s = 0;
      while ((mx >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) begin
         e1[i] = trunc_shift(e1[i], s);
         e2[i] = trunc_shift(e2[i], s);
      end
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      cm = 0;
      for (int i = 0; i < 3; i++) begin
         a = c[i] < 0 ? -c[i] : c[i];
         if (a > cm) cm = a;
      end
      if (cm < 64) begin
         sum = 0;
         for (int i = 0; i < 3; i++) sum += c[i] * c[i];
         if (sum <= (64'd1844 >> (4 * s))) begin
            n0 = 0; n1 = 16384; n2 = 0;
            return;
         end
      end
      unit_vector(c[0], c[1], c[2], n0, n1, n2);
   endfunction

   function automatic tvt_rsp_type make_vertex(input longint px, input longint py,
                                               input longint pz, input longint nx,
                                               input longint ny, input longint nz,
                                               input logic last);
      tvt_rsp_type v;
      v.out_px = px[POS_W-1:0];
      v.out_py = py[POS_W-1:0];
      v.out_pz = pz[POS_W-1:0];
      v.out_nx = nx[NRM_W-1:0];
      v.out_ny = ny[NRM_W-1:0];
      v.out_nz = nz[NRM_W-1:0];
      v.last   = last;
      return v;
   endfunction

   // Transform one vertex and queue the triangle when it closes
   function automatic void transform_vertex(input tvt_req_type item);
      longint p [3];
      longint nin [3];
      longint pos [3];
      longint d [3];
      longint n [3];
      longint f [3];
      longint acc, v, lim;
      int     k;
      if (item.corner == 2'd3) return;
      p   = '{longint'(item.in_px), longint'(item.in_py), longint'(item.in_pz)};
      nin = '{longint'(item.in_nx), longint'(item.in_ny), longint'(item.in_nz)};
      lim = (64'sd1 <<< (POS_W - 1)) - 1;
      for (int r = 0; r < 3; r++) begin
         acc = lane(r, 0) * p[0] + lane(r, 1) * p[1] + lane(r, 2) * p[2];
         v   = ((acc + 2048) >>> 12) + longint'(mat_shift[r]);
         if (v > lim) v = lim;
         if (v < -lim - 1) v = -lim - 1;
         pos[r] = v;
         d[r]   = lane(r, 0) * nin[0] + lane(r, 1) * nin[1] + lane(r, 2) * nin[2];
      end
      if (item.normal_present) unit_vector(d[0], d[1], d[2], n[0], n[1], n[2]);
      else n = '{0, 16384, 0};
      if (item.corner != 2'd2) begin
         k = item.corner;
         for (int i = 0; i < 3; i++) begin
            held_pos[k*3+i] = pos[i];
            held_nrm[k*3+i] = n[i];
         end
         return;
      end
      if (item.face_normal) begin
         flat_normal(pos[0], pos[1], pos[2], f[0], f[1], f[2]);
         vertices_due = {vertices_due, make_vertex(held_pos[0], held_pos[1], held_pos[2],
                                                   f[0], f[1], f[2], 1'b0)};
         vertices_due = {vertices_due, make_vertex(held_pos[3], held_pos[4], held_pos[5],
                                                   f[0], f[1], f[2], 1'b0)};
         vertices_due = {vertices_due, make_vertex(pos[0], pos[1], pos[2],
                                                   f[0], f[1], f[2], 1'b1)};
      end else begin
         vertices_due = {vertices_due, make_vertex(held_pos[0], held_pos[1], held_pos[2],
                                                   held_nrm[0], held_nrm[1], held_nrm[2],
                                                   1'b0)};
         vertices_due = {vertices_due, make_vertex(held_pos[3], held_pos[4], held_pos[5],
                                                   held_nrm[3], held_nrm[4], held_nrm[5],
                                                   1'b0)};
         vertices_due = {vertices_due, make_vertex(pos[0], pos[1], pos[2],
                                                   n[0], n[1], n[2], 1'b1)};
      end
   endfunction

   // Send one vertex beat, idling at random beforehand
   task automatic send_vertex(input tvt_req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      transform_vertex(item);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (vertices_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ROW0:    mat_row[0] = data;
         CSR_ROW1:    mat_row[1] = data;
         CSR_ROW2:    mat_row[2] = data;
         CSR_SHIFT_X: mat_shift[0] = data[POS_W-1:0];
         CSR_SHIFT_Y: mat_shift[1] = data[POS_W-1:0];
         CSR_SHIFT_Z: mat_shift[2] = data[POS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_matrix(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                              input logic [ROW_W-1:0] r2, input logic [POS_W-1:0] sx,
                              input logic [POS_W-1:0] sy, input logic [POS_W-1:0] sz);
      drain_results();
      write_reg(CSR_ROW0, r0);
      write_reg(CSR_ROW1, r1);
      write_reg(CSR_ROW2, r2);
      write_reg(CSR_SHIFT_X, {16'd0, sx});
      write_reg(CSR_SHIFT_Y, {16'd0, sy});
      write_reg(CSR_SHIFT_Z, {16'd0, sz});
      csr_valid <= 1'b0;
   endtask

   function automatic tvt_req_type vertex(input int px, input int py, input int pz,
                                          input int nx, input int ny, input int nz,
                                          input bit has_n, input bit flat,
                                          input logic [1:0] c);
      tvt_req_type item;
      item.in_px = px;
      item.in_py = py;
      item.in_pz = pz;
      item.in_nx = nx[NRM_W-1:0];
      item.in_ny = ny[NRM_W-1:0];
      item.in_nz = nz[NRM_W-1:0];
      item.normal_present = has_n;
      item.face_normal    = flat;
      item.corner         = c;
      return item;
   endfunction

   function automatic logic [POS_W-1:0] rand_coord();
      case ($urandom_range(4))
         0:       return $urandom;
         1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         2:       return 32'(int'($urandom_range(8000)) - 4000);
         default: return 32'(int'($urandom_range(32'h0100_0000)) - 32'h0080_0000);
      endcase
   endfunction

   function automatic logic [NRM_W-1:0] rand_comp();
      case ($urandom_range(3))
         0:       return 16'd0;
         1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic tvt_req_type rand_vertex(input logic [1:0] c);
      tvt_req_type item;
      item.in_px = rand_coord();
      item.in_py = rand_coord();
      item.in_pz = rand_coord();
      item.in_nx = rand_comp();
      item.in_ny = rand_comp();
      item.in_nz = rand_comp();
      item.normal_present = 1'($urandom_range(1));
      item.face_normal    = 1'($urandom_range(1));
      item.corner         = c;
      return item;
   endfunction

   function automatic logic [ROW_W-1:0] rand_row();
      logic [ROW_W-1:0] r;
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(2) == 0) r[16*k +: 16] = 16'($urandom);
         else r[16*k +: 16] = 16'(int'($urandom_range(8192)) - 4096);
      end
      return r;
   endfunction

   // Identity matrix: plain triangles, missing and zero normals
   task automatic test_identity();
      send_vertex(vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16384, 0, 0, 1, 0, 0));
      send_vertex(vertex(-32'sh0001_0000, 5, -7, 0, 0, 0, 0, 1, 1));
      send_vertex(vertex(0, 0, 0, 0, 0, 0, 1, 0, 2));
      send_vertex(vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32767, -32768, 32767, 1, 0, 0));
      send_vertex(vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         -32768, -32768, -32768, 1, 0, 1));
      send_vertex(vertex(32'h7fff_ffff, 32'h8000_0000, 0, 1, -1, 1, 1, 0, 2));
   endtask

   // Face normals: huge edges, degenerate and tiny triangles, stray corners
   task automatic test_face_cases();
      send_vertex(vertex(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
      send_vertex(vertex(32'h7fff_ffff, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0, 1));
      send_vertex(vertex(0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 1, 2));
      send_vertex(vertex(100, 100, 100, 0, 0, 0, 0, 0, 0));
      send_vertex(vertex(100, 100, 100, 0, 0, 0, 0, 0, 1));
      send_vertex(vertex(100, 100, 100, 0, 0, 0, 0, 1, 2));
      send_vertex(vertex(1, 2, 3, 0, 0, 0, 1, 1, 3));
      send_vertex(vertex(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_vertex(vertex(0, 0, 0, 0, 0, 0, 0, 1, 0));
      send_vertex(vertex(1, 0, 0, 0, 0, 0, 0, 0, 1));
      send_vertex(vertex(0, 1, 0, 0, 0, 0, 0, 1, 2));
      send_vertex(vertex(0, 40, 0, 0, 0, 0, 0, 1, 2));
      send_vertex(vertex(-3, 9, 2, 7, 7, 7, 1, 0, 2));
   endtask

   // Saturating matrix with extreme translation
   task automatic test_saturation();
      load_matrix({3{16'h7fff}}, {3{16'h8000}}, 48'h0000_8000_7fff,
                  32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
      send_vertex(vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32767, 32767, 32767, 1, 0, 0));
      send_vertex(vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         -32768, 0, 32767, 1, 0, 1));
      send_vertex(vertex(32'h0001_0000, -32'sh0001_0000, 0, 1, 1, 1, 1, 1, 2));
   endtask

   // Mostly well-formed triangles, some stray corners
   task automatic test_random(input int count, input int idle, input int stall,
                              input bit pause_midway);
      idle_pct  = idle;
      stall_pct = stall;
      for (int t = 0; t < count; t++) begin
         if (pause_midway && t == count / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (vertices_due.size() != 0) @(posedge clock);
         end
         if ($urandom_range(9) == 0) begin
            send_vertex(rand_vertex(2'($urandom_range(3))));
         end else begin
            send_vertex(rand_vertex(2'd0));
            send_vertex(rand_vertex(2'd1));
            send_vertex(rand_vertex(2'd2));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_ROW0;
      csr_data    = '0;
      idle_pct     = 0;
      stall_pct    = 0;
      mat_row   = '{48'd4096, 48'd4096 << 16, 48'd4096 << 32};
      mat_shift = '{32'd0, 32'd0, 32'd0};
      for (int i = 0; i < 6; i++) begin
         held_pos[i] = 0;
         held_nrm[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity();
      test_face_cases();
      test_saturation();
      load_matrix(rand_row(), rand_row(), rand_row(), $urandom, $urandom, $urandom);
      test_random(25, 0, 0, 1'b0);
      load_matrix(48'd4096, 48'd4096 << 16, 48'd4096 << 32, 32'd0, 32'd0, 32'd0);
      test_random(25, 52, 0, 1'b1);
      load_matrix({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      test_random(10, 0, 52, 1'b0);
      load_matrix(48'd0, 48'd0, 48'd0, $urandom, $urandom, $urandom);
      test_random(5, 32, 32, 1'b0);
      load_matrix(rand_row(), rand_row(), rand_row(), $urandom, $urandom, $urandom);
      test_random(20, 32, 32, 1'b0);
      load_matrix(rand_row(), rand_row(), rand_row(), 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff);
      test_random(20, 0, 52, 1'b0);

      drain_results();
      if (errors == 0 && vertices_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
